>>> src/topology_mirror_pairing_defines.svh
// ----------------------------------------------------------------------------
// Topology mirror pairing: assertion macros
// Shared assertion helpers; they compile to nothing when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef TOPOLOGY_MIRROR_PAIRING_DEFINES_SVH
`define TOPOLOGY_MIRROR_PAIRING_DEFINES_SVH

`ifndef SYNTHESIS
// condition must never hold while out of reset
`define TMP_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("tmp assertion failed");
// antecedent implies consequent in the same cycle
`define TMP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tmp assertion failed");
// antecedent implies consequent in the next cycle
`define TMP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tmp assertion failed");
`else
`define TMP_ASSERT_NEVER(lbl, clk, rst_n, expr)
`define TMP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define TMP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> src/tmp_pkg.sv
// ----------------------------------------------------------------------------
// Topology mirror pairing package
// Sizes, op codes and sequencer states shared by the block.
// ----------------------------------------------------------------------------
package tmp_pkg;
    localparam int MAX_VERTICES = 1024;
    localparam int MAX_EDGES    = 4096;
    localparam int MAX_PASSES   = 4096;

    localparam int VW  = 10;          // vertex index
    localparam int EAW = 12;          // edge store address
    localparam int ETW = 13;          // edge count
    localparam int NW  = 11;          // vertex count
    localparam int HW  = 32;          // hash
    localparam int PW  = 13;          // pass number
    localparam int KW  = HW + VW;     // sort key {hash, vertex}
    localparam int MW  = VW + 1;      // mirror entry {valid, vertex}

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_FINISH = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE,
        S_QRY,
        S_CLR,
        S_DEG_RD,
        S_DEG_EDGE,
        S_DEG_HASH,
        S_DEG_WB,
        S_CPY_RD,
        S_CPY_WR,
        S_PS_RD,
        S_PS_EDGE,
        S_PS_DATA,
        S_PS_MA,
        S_PS_WA,
        S_PS_WB,
        S_SRT_BLK,
        S_SRT_RD,
        S_SRT_WR,
        S_SCN_RD,
        S_SCN_DAT,
        S_SCN_END,
        S_SCN_W2,
        S_DECIDE,
        S_DONE
    } t_state;
endpackage

>>> src/tmp_in_if.sv
// ----------------------------------------------------------------------------
// Topology mirror pairing input channel
// Valid/ready channel carrying one command word.
// ----------------------------------------------------------------------------
interface tmp_in_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 op;
    logic [tmp_pkg::VW-1:0]     first_vertex;
    logic [tmp_pkg::VW-1:0]     second_vertex;

    modport source (output valid, output op, output first_vertex, output second_vertex,
                    input ready);
    modport sink (input valid, input op, input first_vertex, input second_vertex,
                  output ready);
endinterface

>>> src/tmp_out_if.sv
// ----------------------------------------------------------------------------
// Topology mirror pairing output channel
// Valid/ready channel carrying one reply word.
// ----------------------------------------------------------------------------
interface tmp_out_if;
    logic                       valid;
    logic                       ready;
    logic                       reply_kind;
    logic [tmp_pkg::VW-1:0]     mirror_vertex;
    logic                       has_mirror;
    logic [tmp_pkg::PW-1:0]     pass_count;
    logic [tmp_pkg::NW-1:0]     unique_hashes;
    logic                       edge_overflow;
    logic                       pass_cap_hit;

    modport source (output valid, output reply_kind, output mirror_vertex,
                    output has_mirror, output pass_count, output unique_hashes,
                    output edge_overflow, output pass_cap_hit, input ready);
    modport sink (input valid, input reply_kind, input mirror_vertex,
                  input has_mirror, input pass_count, input unique_hashes,
                  input edge_overflow, input pass_cap_hit, output ready);
endinterface

>>> src/topology_mirror_pairing.sv
// ----------------------------------------------------------------------------
// Topology mirror pairing
// Loads edges, refines vertex hashes pass by pass with one shared multiplier
// and a merge sorter, then pairs vertices by hash and answers mirror queries.
// ----------------------------------------------------------------------------
// Load: no reply. Query: the mirror entry is read on accept and the reply is
// registered from state S_QRY. Finish: its run time grows with the stored
// edges, the vertices and the passes; the per-edge read-modify-write through
// the hash RAM and the merge step of the sorter set it.
// Not ready while a finish runs. Reset (synchronous, active low) empties the
// edge store, clears the flags, and marks the mirror table as never built.
// ----------------------------------------------------------------------------
`include "topology_mirror_pairing_defines.svh"

module topology_mirror_pairing (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [tmp_pkg::NW-1:0]  i_cfg_wdata,
    tmp_in_if.sink                  i_in,
    tmp_out_if.source               o_out
);
    localparam int VW  = tmp_pkg::VW;
    localparam int EAW = tmp_pkg::EAW;
    localparam int ETW = tmp_pkg::ETW;
    localparam int NW  = tmp_pkg::NW;
    localparam int HW  = tmp_pkg::HW;
    localparam int PW  = tmp_pkg::PW;
    localparam int KW  = tmp_pkg::KW;
    localparam int MW  = tmp_pkg::MW;
    localparam int CW  = tmp_pkg::NW + 1;

    // control registers
    tmp_pkg::t_state r_state, n_state;
    logic            r_ov, n_ov;
    logic [ETW-1:0]  r_total, n_total;
    logic            r_oflow, n_oflow;
    logic [NW-1:0]   r_vc, n_vc;
    logic            r_done_once, n_done_once;
    logic [NW-1:0]   r_idx, n_idx;
    logic [ETW-1:0]  r_edge, n_edge;
    logic [PW-1:0]   r_pass, n_pass;
    logic [ETW-1:0]  r_diff, n_diff;
    logic [ETW-1:0]  r_prev_diff, n_prev_diff;
    logic [NW-1:0]   r_uniq, n_uniq;
    logic [NW-1:0]   r_prev_uniq, n_prev_uniq;
    logic            r_have_prev, n_have_prev;
    logic            r_cap, n_cap;
    logic            r_final, n_final;
    logic            r_init, n_init;
    logic            r_last, n_last;
    logic [NW-1:0]   r_w, n_w;
    logic [CW-1:0]   r_lo, n_lo;
    logic            r_src, n_src;

    // payload registers
    logic [VW-1:0]   r_a, n_a, r_b, n_b;
    logic [HW-1:0]   r_ca, n_ca, r_cb, n_cb, r_pa, n_pa, r_pb, n_pb;
    logic [HW-1:0]   r_new_a, n_new_a;
    logic [CW-1:0]   r_mid, n_mid, r_hi, n_hi;
    logic [NW-1:0]   r_i, n_i, r_j, n_j, r_k, n_k;
    logic [HW-1:0]   r_gh, n_gh;
    logic [1:0]      r_gsz, n_gsz;
    logic [VW-1:0]   r_gv0, n_gv0, r_gv1, n_gv1;
    logic [VW-1:0]   r_pend_a, n_pend_a, r_pend_v, n_pend_v;
    logic            r_kind, n_kind;
    logic [VW-1:0]   r_mv, n_mv;
    logic            r_has, n_has;
    logic [PW-1:0]   r_pc, n_pc;
    logic [NW-1:0]   r_uq, n_uq;
    logic            r_of, n_of;
    logic            r_pcap, n_pcap;

    // memory ports
    logic            e_we;
    logic [EAW-1:0]  e_waddr, e_raddr;
    logic [2*VW-1:0] e_wdata, e_rda;
    logic            c_we;
    logic [VW-1:0]   c_waddr, c_ra, c_rb;
    logic [HW-1:0]   c_wdata, c_rda, c_rdb;
    logic            p_we;
    logic [VW-1:0]   p_waddr;
    logic [HW-1:0]   p_wdata, p_rda, p_rdb;
    logic            sa_we, sb_we;
    logic [VW-1:0]   s_waddr, s_ra, s_rb;
    logic [KW-1:0]   s_wdata, sa_rda, sa_rdb, sb_rda, sb_rdb;
    logic            m_we;
    logic [VW-1:0]   m_waddr, m_ra;
    logic [MW-1:0]   m_wdata, m_rda;

    // datapath helpers
    logic [NW-1:0]   w_n;
    logic [VW-1:0]   w_ea, w_eb;
    logic            w_eok;
    logic [KW-1:0]   w_sd_a, w_sd_b;
    logic [HW-1:0]   w_sh;
    logic [VW-1:0]   w_su;
    logic [HW-1:0]   w_mop, w_prod, w_sum_a, w_sum_b;
    logic            w_take_j;
    logic            w_acc;
    logic            w_fin_acc;
    logic            w_stop;

    assign w_n    = (r_vc > NW'(tmp_pkg::MAX_VERTICES)) ? NW'(tmp_pkg::MAX_VERTICES) : r_vc;
    assign w_ea   = e_rda[VW-1:0];
    assign w_eb   = e_rda[2*VW-1:VW];
    assign w_eok  = ({1'b0, w_ea} < w_n) && ({1'b0, w_eb} < w_n);
    assign w_sd_a = r_src ? sb_rda : sa_rda;
    assign w_sd_b = r_src ? sb_rdb : sa_rdb;
    assign w_sh   = w_sd_a[KW-1:VW];
    assign w_su   = w_sd_a[VW-1:0];
    assign w_mop  = (r_state == tmp_pkg::S_PS_WA) ? r_pa : r_pb;
    assign w_sum_a = r_ca + w_prod;
    assign w_sum_b = r_cb + w_prod;
    assign w_take_j = ({1'b0, r_j} < r_hi) && (({1'b0, r_i} >= r_mid) || (w_sd_b < w_sd_a));
    assign w_acc  = i_in.valid & i_in.ready;
    assign w_fin_acc = w_acc && (i_in.op == tmp_pkg::OP_FINISH);
    assign w_stop = r_have_prev && (r_uniq <= r_prev_uniq) && (r_diff <= r_prev_diff);

    assign i_in.ready = (r_state == tmp_pkg::S_IDLE) && (!r_ov || o_out.ready);

    assign o_out.valid         = r_ov;
    assign o_out.reply_kind    = r_kind;
    assign o_out.mirror_vertex = r_mv;
    assign o_out.has_mirror    = r_has;
    assign o_out.pass_count    = r_pc;
    assign o_out.unique_hashes = r_uq;
    assign o_out.edge_overflow = r_of;
    assign o_out.pass_cap_hit  = r_pcap;

    // memories
    tmp_ram #(.WIDTH(2*VW), .DEPTH(tmp_pkg::MAX_EDGES)) u_edge_ram (
        .i_clk(i_clk), .i_we(e_we), .i_waddr(e_waddr), .i_wdata(e_wdata),
        .i_raddr_a(e_raddr), .i_raddr_b(e_raddr), .o_rdata_a(e_rda), .o_rdata_b()
    );
    tmp_ram #(.WIDTH(HW), .DEPTH(tmp_pkg::MAX_VERTICES)) u_cur_ram (
        .i_clk(i_clk), .i_we(c_we), .i_waddr(c_waddr), .i_wdata(c_wdata),
        .i_raddr_a(c_ra), .i_raddr_b(c_rb), .o_rdata_a(c_rda), .o_rdata_b(c_rdb)
    );
    tmp_ram #(.WIDTH(HW), .DEPTH(tmp_pkg::MAX_VERTICES)) u_prev_ram (
        .i_clk(i_clk), .i_we(p_we), .i_waddr(p_waddr), .i_wdata(p_wdata),
        .i_raddr_a(w_ea), .i_raddr_b(w_eb), .o_rdata_a(p_rda), .o_rdata_b(p_rdb)
    );
    tmp_ram #(.WIDTH(KW), .DEPTH(tmp_pkg::MAX_VERTICES)) u_sort_a_ram (
        .i_clk(i_clk), .i_we(sa_we), .i_waddr(s_waddr), .i_wdata(s_wdata),
        .i_raddr_a(s_ra), .i_raddr_b(s_rb), .o_rdata_a(sa_rda), .o_rdata_b(sa_rdb)
    );
    tmp_ram #(.WIDTH(KW), .DEPTH(tmp_pkg::MAX_VERTICES)) u_sort_b_ram (
        .i_clk(i_clk), .i_we(sb_we), .i_waddr(s_waddr), .i_wdata(s_wdata),
        .i_raddr_a(s_ra), .i_raddr_b(s_rb), .o_rdata_a(sb_rda), .o_rdata_b(sb_rdb)
    );
    tmp_ram #(.WIDTH(MW), .DEPTH(tmp_pkg::MAX_VERTICES)) u_mirror_ram (
        .i_clk(i_clk), .i_we(m_we), .i_waddr(m_waddr), .i_wdata(m_wdata),
        .i_raddr_a(m_ra), .i_raddr_b(m_ra), .o_rdata_a(m_rda), .o_rdata_b()
    );

    // shared multiplier
    tmp_mult u_mult (
        .i_clk(i_clk), .i_a(w_mop), .i_b(r_pass), .o_p(w_prod)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tmp_pkg::S_IDLE;
            r_ov        <= 1'b0;
            r_total     <= '0;
            r_oflow     <= 1'b0;
            r_vc        <= '0;
            r_done_once <= 1'b0;
            r_idx       <= '0;
            r_edge      <= '0;
            r_pass      <= '0;
            r_diff      <= '0;
            r_prev_diff <= '0;
            r_uniq      <= '0;
            r_prev_uniq <= '0;
            r_have_prev <= 1'b0;
            r_cap       <= 1'b0;
            r_final     <= 1'b0;
            r_init      <= 1'b0;
            r_last      <= 1'b0;
            r_w         <= '0;
            r_lo        <= '0;
            r_src       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ov        <= n_ov;
            r_total     <= n_total;
            r_oflow     <= n_oflow;
            r_vc        <= n_vc;
            r_done_once <= n_done_once;
            r_idx       <= n_idx;
            r_edge      <= n_edge;
            r_pass      <= n_pass;
            r_diff      <= n_diff;
            r_prev_diff <= n_prev_diff;
            r_uniq      <= n_uniq;
            r_prev_uniq <= n_prev_uniq;
            r_have_prev <= n_have_prev;
            r_cap       <= n_cap;
            r_final     <= n_final;
            r_init      <= n_init;
            r_last      <= n_last;
            r_w         <= n_w;
            r_lo        <= n_lo;
            r_src       <= n_src;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_a <= n_a;   r_b <= n_b;
        r_ca <= n_ca; r_cb <= n_cb; r_pa <= n_pa; r_pb <= n_pb;
        r_new_a <= n_new_a;
        r_mid <= n_mid; r_hi <= n_hi;
        r_i <= n_i;   r_j <= n_j;   r_k <= n_k;
        r_gh <= n_gh; r_gsz <= n_gsz; r_gv0 <= n_gv0; r_gv1 <= n_gv1;
        r_pend_a <= n_pend_a; r_pend_v <= n_pend_v;
        r_kind <= n_kind; r_mv <= n_mv; r_has <= n_has; r_pc <= n_pc;
        r_uq <= n_uq; r_of <= n_of; r_pcap <= n_pcap;
    end

    // sequencer
    always_comb begin
        n_state = r_state;   n_ov = r_ov & ~o_out.ready;
        n_total = r_total;   n_oflow = r_oflow;
        n_vc = i_cfg_we ? i_cfg_wdata : r_vc;
        n_done_once = r_done_once;
        n_idx = r_idx;       n_edge = r_edge;     n_pass = r_pass;
        n_diff = r_diff;     n_prev_diff = r_prev_diff;
        n_uniq = r_uniq;     n_prev_uniq = r_prev_uniq;
        n_have_prev = r_have_prev;  n_cap = r_cap;
        n_final = r_final;   n_init = r_init;     n_last = r_last;
        n_w = r_w;           n_lo = r_lo;         n_src = r_src;
        n_a = r_a;   n_b = r_b;
        n_ca = r_ca; n_cb = r_cb; n_pa = r_pa; n_pb = r_pb;
        n_new_a = r_new_a;
        n_mid = r_mid; n_hi = r_hi;
        n_i = r_i;   n_j = r_j;   n_k = r_k;
        n_gh = r_gh; n_gsz = r_gsz; n_gv0 = r_gv0; n_gv1 = r_gv1;
        n_pend_a = r_pend_a; n_pend_v = r_pend_v;
        n_kind = r_kind; n_mv = r_mv; n_has = r_has; n_pc = r_pc;
        n_uq = r_uq; n_of = r_of; n_pcap = r_pcap;

        e_we = 1'b0; e_waddr = r_total[EAW-1:0];
        e_wdata = {i_in.second_vertex, i_in.first_vertex};
        e_raddr = r_edge[EAW-1:0];
        c_we = 1'b0; c_waddr = r_idx[VW-1:0]; c_wdata = '0; c_ra = w_ea; c_rb = w_eb;
        p_we = 1'b0; p_waddr = r_idx[VW-1:0]; p_wdata = c_rda;
        sa_we = 1'b0; sb_we = 1'b0; s_waddr = r_idx[VW-1:0];
        s_wdata = {c_rda, r_idx[VW-1:0]};
        s_ra = r_idx[VW-1:0]; s_rb = r_j[VW-1:0];
        m_we = 1'b0; m_waddr = r_idx[VW-1:0]; m_wdata = '0; m_ra = i_in.first_vertex;

        unique case (r_state)
            tmp_pkg::S_IDLE: begin
                if (w_acc) begin
                    case (i_in.op)
                        tmp_pkg::OP_LOAD: begin
                            // store edge or flag the drop
                            if (r_total < ETW'(tmp_pkg::MAX_EDGES)) begin
                                e_we = 1'b1;
                                n_total = r_total + 1'b1;
                            end else begin
                                n_oflow = 1'b1;
                            end
                        end
                        tmp_pkg::OP_FINISH: begin
                            n_idx = '0;
                            n_init = 1'b1;
                            n_pass = PW'(1);
                            n_diff = '0;
                            n_have_prev = 1'b0;
                            n_cap = 1'b0;
                            n_final = 1'b0;
                            n_state = tmp_pkg::S_CLR;
                        end
                        tmp_pkg::OP_QUERY: begin
                            n_state = tmp_pkg::S_QRY;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            tmp_pkg::S_QRY: begin
                // mirror entry is ready; answer
                n_ov   = 1'b1;
                n_kind = 1'b1;
                n_has  = m_rda[MW-1] & r_done_once;
                n_mv   = (m_rda[MW-1] & r_done_once) ? m_rda[VW-1:0] : '0;
                n_pc   = '0;
                n_uq   = '0;
                n_of   = 1'b0;
                n_pcap = 1'b0;
                n_state = tmp_pkg::S_IDLE;
            end
            tmp_pkg::S_CLR: begin
                // zero hashes and mirror table, one entry a cycle
                c_we = 1'b1;
                m_we = 1'b1;
                n_idx = r_idx + 1'b1;
                if (r_idx == NW'(tmp_pkg::MAX_VERTICES - 1)) begin
                    n_edge = '0;
                    n_state = tmp_pkg::S_DEG_RD;
                end
            end
            tmp_pkg::S_DEG_RD: begin
                if (r_edge == r_total) begin
                    n_idx = '0;
                    n_state = tmp_pkg::S_CPY_RD;
                end else begin
                    n_state = tmp_pkg::S_DEG_EDGE;
                end
            end
            tmp_pkg::S_DEG_EDGE: begin
                n_a = w_ea;
                n_b = w_eb;
                if (w_eok) begin
                    n_state = tmp_pkg::S_DEG_HASH;
                end else begin
                    n_edge = r_edge + 1'b1;
                    n_state = tmp_pkg::S_DEG_RD;
                end
            end
            tmp_pkg::S_DEG_HASH: begin
                // bump first endpoint; a self loop counts twice
                c_we = 1'b1;
                c_waddr = r_a;
                c_wdata = c_rda + ((r_a == r_b) ? HW'(2) : HW'(1));
                n_cb = c_rdb;
                if (r_a == r_b) begin
                    n_edge = r_edge + 1'b1;
                    n_state = tmp_pkg::S_DEG_RD;
                end else begin
                    n_state = tmp_pkg::S_DEG_WB;
                end
            end
            tmp_pkg::S_DEG_WB: begin
                c_we = 1'b1;
                c_waddr = r_b;
                c_wdata = r_cb + HW'(1);
                n_edge = r_edge + 1'b1;
                n_state = tmp_pkg::S_DEG_RD;
            end
            tmp_pkg::S_CPY_RD: begin
                c_ra = r_idx[VW-1:0];
                if (r_idx == w_n) begin
                    if (r_init) begin
                        n_init = 1'b0;
                        n_edge = '0;
                        n_diff = '0;
                        n_state = tmp_pkg::S_PS_RD;
                    end else begin
                        n_w = NW'(1);
                        n_lo = '0;
                        n_src = 1'b0;
                        n_state = tmp_pkg::S_SRT_BLK;
                    end
                end else begin
                    n_state = tmp_pkg::S_CPY_WR;
                end
            end
            tmp_pkg::S_CPY_WR: begin
                // snapshot hash into previous and sort buffer
                p_we = 1'b1;
                sa_we = 1'b1;
                n_idx = r_idx + 1'b1;
                n_state = tmp_pkg::S_CPY_RD;
            end
            tmp_pkg::S_PS_RD: begin
                if (r_edge == r_total) begin
                    n_idx = '0;
                    n_state = tmp_pkg::S_CPY_RD;
                end else begin
                    n_state = tmp_pkg::S_PS_EDGE;
                end
            end
            tmp_pkg::S_PS_EDGE: begin
                n_a = w_ea;
                n_b = w_eb;
                if (w_eok) begin
                    n_state = tmp_pkg::S_PS_DATA;
                end else begin
                    n_edge = r_edge + 1'b1;
                    n_state = tmp_pkg::S_PS_RD;
                end
            end
            tmp_pkg::S_PS_DATA: begin
                n_ca = c_rda;
                n_cb = c_rdb;
                n_pa = p_rda;
                n_pb = p_rdb;
                n_state = tmp_pkg::S_PS_MA;
            end
            tmp_pkg::S_PS_MA: begin
                n_state = tmp_pkg::S_PS_WA;
            end
            tmp_pkg::S_PS_WA: begin
                // first endpoint takes the other's previous hash times pass
                c_we = 1'b1;
                c_waddr = r_a;
                c_wdata = w_sum_a;
                n_new_a = w_sum_a;
                if (r_a == r_b) begin
                    n_cb = w_sum_a;
                end
                n_state = tmp_pkg::S_PS_WB;
            end
            tmp_pkg::S_PS_WB: begin
                c_we = 1'b1;
                c_waddr = r_b;
                c_wdata = w_sum_b;
                if ((r_a != r_b) && (r_new_a != w_sum_b)) begin
                    n_diff = r_diff + 1'b1;
                end
                n_edge = r_edge + 1'b1;
                n_state = tmp_pkg::S_PS_RD;
            end
            tmp_pkg::S_SRT_BLK: begin
                // next merge block, next width, or done
                if (r_w >= w_n) begin
                    n_idx = '0;
                    n_uniq = '0;
                    n_last = 1'b0;
                    n_state = tmp_pkg::S_SCN_RD;
                end else if (r_lo >= CW'(w_n)) begin
                    n_w = {r_w[NW-2:0], 1'b0};
                    n_lo = '0;
                    n_src = ~r_src;
                end else begin
                    n_mid = ((r_lo + CW'(r_w)) < CW'(w_n)) ? (r_lo + CW'(r_w)) : CW'(w_n);
                    n_hi = ((r_lo + CW'({r_w, 1'b0})) < CW'(w_n)) ?
                           (r_lo + CW'({r_w, 1'b0})) : CW'(w_n);
                    n_i = r_lo[NW-1:0];
                    n_k = r_lo[NW-1:0];
                    n_j = ((r_lo + CW'(r_w)) < CW'(w_n)) ?
                          NW'(r_lo + CW'(r_w)) : w_n;
                    n_state = tmp_pkg::S_SRT_RD;
                end
            end
            tmp_pkg::S_SRT_RD: begin
                s_ra = r_i[VW-1:0];
                n_state = tmp_pkg::S_SRT_WR;
            end
            tmp_pkg::S_SRT_WR: begin
                // emit the smaller head into the other buffer
                s_waddr = r_k[VW-1:0];
                s_wdata = w_take_j ? w_sd_b : w_sd_a;
                sa_we = r_src;
                sb_we = ~r_src;
                if (w_take_j) begin
                    n_j = r_j + 1'b1;
                end else begin
                    n_i = r_i + 1'b1;
                end
                n_k = r_k + 1'b1;
                if (CW'(r_k) + CW'(1) == r_hi) begin
                    n_lo = r_lo + CW'({r_w, 1'b0});
                    n_state = tmp_pkg::S_SRT_BLK;
                end else begin
                    n_state = tmp_pkg::S_SRT_RD;
                end
            end
            tmp_pkg::S_SCN_RD: begin
                if (r_idx == w_n) begin
                    n_state = tmp_pkg::S_SCN_END;
                end else begin
                    n_state = tmp_pkg::S_SCN_DAT;
                end
            end
            tmp_pkg::S_SCN_DAT: begin
                // walk sorted keys, count groups, pair on the final walk
                n_idx = r_idx + 1'b1;
                n_state = tmp_pkg::S_SCN_RD;
                if ((r_idx == '0) || (w_sh != r_gh)) begin
                    if ((r_idx != '0) && r_final) begin
                        if (r_gsz == 2'd1) begin
                            m_we = 1'b1;
                            m_waddr = r_gv0;
                            m_wdata = {1'b1, r_gv0};
                        end else if (r_gsz == 2'd2) begin
                            m_we = 1'b1;
                            m_waddr = r_gv0;
                            m_wdata = {1'b1, r_gv1};
                            n_pend_a = r_gv1;
                            n_pend_v = r_gv0;
                            n_last = 1'b0;
                            n_state = tmp_pkg::S_SCN_W2;
                        end
                    end
                    n_uniq = r_uniq + 1'b1;
                    n_gh = w_sh;
                    n_gsz = 2'd1;
                    n_gv0 = w_su;
                end else begin
                    if (r_gsz == 2'd1) begin
                        n_gv1 = w_su;
                    end
                    if (r_gsz != 2'd3) begin
                        n_gsz = r_gsz + 2'd1;
                    end
                end
            end
            tmp_pkg::S_SCN_END: begin
                // close the last group
                n_state = r_final ? tmp_pkg::S_DONE : tmp_pkg::S_DECIDE;
                if ((w_n != '0) && r_final) begin
                    if (r_gsz == 2'd1) begin
                        m_we = 1'b1;
                        m_waddr = r_gv0;
                        m_wdata = {1'b1, r_gv0};
                    end else if (r_gsz == 2'd2) begin
                        m_we = 1'b1;
                        m_waddr = r_gv0;
                        m_wdata = {1'b1, r_gv1};
                        n_pend_a = r_gv1;
                        n_pend_v = r_gv0;
                        n_last = 1'b1;
                        n_state = tmp_pkg::S_SCN_W2;
                    end
                end
            end
            tmp_pkg::S_SCN_W2: begin
                m_we = 1'b1;
                m_waddr = r_pend_a;
                m_wdata = {1'b1, r_pend_v};
                if (r_last) begin
                    n_state = r_final ? tmp_pkg::S_DONE : tmp_pkg::S_DECIDE;
                end else begin
                    n_state = tmp_pkg::S_SCN_RD;
                end
            end
            tmp_pkg::S_DECIDE: begin
                // stop when neither count grew, or at the pass cap
                if (w_stop || (r_pass >= PW'(tmp_pkg::MAX_PASSES))) begin
                    n_cap = ~w_stop;
                    n_final = 1'b1;
                    n_idx = '0;
                    n_uniq = '0;
                    n_state = tmp_pkg::S_SCN_RD;
                end else begin
                    n_prev_uniq = r_uniq;
                    n_prev_diff = r_diff;
                    n_have_prev = 1'b1;
                    n_pass = r_pass + 1'b1;
                    n_diff = '0;
                    n_edge = '0;
                    n_state = tmp_pkg::S_PS_RD;
                end
            end
            tmp_pkg::S_DONE: begin
                n_ov = 1'b1;
                n_kind = 1'b0;
                n_mv = '0;
                n_has = 1'b0;
                n_pc = r_pass;
                n_uq = r_uniq;
                n_of = r_oflow;
                n_pcap = r_cap;
                n_done_once = 1'b1;
                n_state = tmp_pkg::S_IDLE;
            end
            default: begin
                n_state = tmp_pkg::S_IDLE;
            end
        endcase
    end

    // checks
    `TMP_ASSERT_IMPLY(a_ready_idle, i_clk, i_rst_n, i_in.ready, r_state == tmp_pkg::S_IDLE)
    `TMP_ASSERT_NEXT(a_finish_starts, i_clk, i_rst_n, w_fin_acc, r_state == tmp_pkg::S_CLR)
    `TMP_ASSERT_NEVER(a_pass_bound, i_clk, i_rst_n, r_pass > PW'(tmp_pkg::MAX_PASSES))
    `TMP_ASSERT_NEVER(a_edge_bound, i_clk, i_rst_n, r_total > ETW'(tmp_pkg::MAX_EDGES))
endmodule

>>> src/tmp_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module tmp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_a;
    logic [WIDTH-1:0] r_rd_b;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered reads
    always_ff @(posedge i_clk) begin
        r_rd_a <= r_mem[i_raddr_a];
        r_rd_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rd_a;
    assign o_rdata_b = r_rd_b;
endmodule

>>> src/tmp_mult.sv
// ----------------------------------------------------------------------------
// Shared hash multiplier
// Registered hash times pass number, truncated to the hash width.
// ----------------------------------------------------------------------------
module tmp_mult (
    input  logic                    i_clk,
    input  logic [tmp_pkg::HW-1:0]  i_a,
    input  logic [tmp_pkg::PW-1:0]  i_b,
    output logic [tmp_pkg::HW-1:0]  o_p
);
    localparam int FW = tmp_pkg::HW + tmp_pkg::PW;

    logic [FW-1:0]          w_full;
    logic [tmp_pkg::HW-1:0] r_p;

    // full product, keep the low word
    assign w_full = FW'(i_a) * FW'(i_b);

    always_ff @(posedge i_clk) begin
        r_p <= w_full[tmp_pkg::HW-1:0];
    end

    assign o_p = r_p;
endmodule
